FILE: sv/hvc_pkg.sv
// Shared types and constants for the HTTP header value capture block.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hvc_pkg;

	// Parameter defaults.
	localparam int VALUE_MAX_DEF  = 64;
	localparam int NAME_BYTES_DEF = 24;

	// Fixed field and register widths.
	localparam int NameSlots     = 24;
	localparam int NameLenW      = 5;
	localparam int CfgWordW      = 64;
	localparam int CfgAddrW      = 2;
	localparam int ByteW         = 8;
	localparam int StatusW       = 2;
	localparam int OutDataW      = 16;

	localparam logic [NameLenW-1:0] NAME_LEN_RESET = 5'd22;

	// Configuration register indexes.
	localparam logic [CfgAddrW-1:0] CFG_WORD_LOW  = 2'd0;
	localparam logic [CfgAddrW-1:0] CFG_WORD_MID  = 2'd1;
	localparam logic [CfgAddrW-1:0] CFG_WORD_HIGH = 2'd2;
	localparam logic [CfgAddrW-1:0] CFG_NAME_LEN  = 2'd3;

	// Result status codes.
	localparam logic [StatusW-1:0] ST_ABSENT  = 2'd0;
	localparam logic [StatusW-1:0] ST_PRESENT = 2'd1;
	localparam logic [StatusW-1:0] ST_INVALID = 2'd2;

	// Special request bytes.
	localparam logic [ByteW-1:0] CH_NUL   = 8'h00;
	localparam logic [ByteW-1:0] CH_TAB   = 8'h09;
	localparam logic [ByteW-1:0] CH_LF    = 8'h0A;
	localparam logic [ByteW-1:0] CH_CR    = 8'h0D;
	localparam logic [ByteW-1:0] CH_SPACE = 8'h20;
	localparam logic [ByteW-1:0] CH_COLON = 8'h3A;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic take;      // parse the byte on the input channel
		logic replay;    // parse the held byte as line content
		logic clear;     // return the parse state to its reset value
		logic rd_en;     // read the value store
		logic rd_first;  // read at the current index instead of the next one
		logic load_out;  // load the output register
		logic next_idx;  // advance the result index
	} hvc_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic need_replay; // the input byte needs a second content step
		logic out_last;    // the loaded result item closes the run
	} hvc_sts_t;

endpackage

`default_nettype wire

FILE: sv/hvc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module hvc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

FILE: sv/hvc_ctrl.sv
// Controller state machine: input parsing, the replay step and the result run.
// Depends on hvc_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module hvc_ctrl
	import hvc_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	input  wire logic     in_last,
	output logic          in_ready,
	input  wire logic     out_ready,
	output logic          out_valid,
	input  wire hvc_sts_t sts,
	output hvc_cmd_t      cmd
);

	typedef enum logic [2:0] {
		S_RUN,
		S_REPLAY,
		S_EMIT_RD,
		S_EMIT_LD,
		S_EMIT_WAIT
	} state_t;

	state_t state_q;
	logic   held_last_q;

	assign in_ready = (state_q == S_RUN);

	always_comb begin
		cmd = '0;
		case (state_q)
			S_RUN: begin
				cmd.take = in_valid;
			end
			S_REPLAY: begin
				cmd.replay = 1'b1;
			end
			S_EMIT_RD: begin
				cmd.rd_en    = 1'b1;
				cmd.rd_first = 1'b1;
			end
			S_EMIT_LD: begin
				cmd.load_out = 1'b1;
			end
			S_EMIT_WAIT: begin
				// Prefetch the next entry so it is ready when this transfer completes.
				cmd.rd_en = 1'b1;
				if (out_ready) begin
					cmd.clear    = sts.out_last;
					cmd.next_idx = !sts.out_last;
				end
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_RUN;
			held_last_q <= 1'b0;
			out_valid   <= 1'b0;
		end else begin
			case (state_q)
				S_RUN: begin
					if (in_valid) begin
						held_last_q <= in_last;
						if (sts.need_replay) begin
							state_q <= S_REPLAY;
						end else if (in_last) begin
							state_q <= S_EMIT_RD;
						end
					end
				end
				S_REPLAY: begin
					state_q <= held_last_q ? S_EMIT_RD : S_RUN;
				end
				S_EMIT_RD: begin
					state_q <= S_EMIT_LD;
				end
				S_EMIT_LD: begin
					out_valid <= 1'b1;
					state_q   <= S_EMIT_WAIT;
				end
				S_EMIT_WAIT: begin
					if (out_ready) begin
						out_valid <= 1'b0;
						state_q   <= sts.out_last ? S_RUN : S_EMIT_LD;
					end
				end
				default: begin
					state_q <= S_RUN;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: sv/hvc_dp.sv
// Datapath: configuration registers, header line parser, value store and
// output register. Depends on hvc_pkg and hvc_ram.
`timescale 1ns / 1ps
`default_nettype none

module hvc_dp
	import hvc_pkg::*;
#(
	parameter int VALUE_MAX  = VALUE_MAX_DEF,
	parameter int NAME_BYTES = NAME_BYTES_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [CfgAddrW-1:0] cfg_addr,
	input  wire logic [CfgWordW-1:0] cfg_data,
	input  wire logic [ByteW-1:0]    in_byte,
	input  wire hvc_cmd_t            cmd,
	output hvc_sts_t                 sts,
	output logic      [StatusW-1:0]  out_status,
	output logic      [ByteW-1:0]    out_byte,
	output logic                     out_last
);

	localparam int AddrW = $clog2(VALUE_MAX);
	localparam int LenW  = $clog2(VALUE_MAX + 1);

	typedef enum logic [2:0] {
		PH_LINE_START,
		PH_NAME,
		PH_BLANKS,
		PH_VALUE,
		PH_OTHER,
		PH_FOLDED,
		PH_STOPPED
	} phase_t;

	function automatic logic [ByteW-1:0] fold_lower(input logic [ByteW-1:0] b);
		if (b >= 8'h41 && b <= 8'h5A) begin
			return b + 8'h20;
		end
		return b;
	endfunction

	// Configuration.
	logic [CfgWordW-1:0] word_low_q, word_mid_q, word_high_q;
	logic [NameLenW-1:0] name_len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_low_q  <= '0;
			word_mid_q  <= '0;
			word_high_q <= '0;
			name_len_q  <= NAME_LEN_RESET;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_WORD_LOW:  word_low_q  <= cfg_data;
				CFG_WORD_MID:  word_mid_q  <= cfg_data;
				CFG_WORD_HIGH: word_high_q <= cfg_data;
				CFG_NAME_LEN:  name_len_q  <= cfg_data[NameLenW-1:0];
				default: ;
			endcase
		end
	end

	logic [ByteW-1:0]    name_tab [NameSlots];
	logic [NameLenW-1:0] eff_len;

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			name_tab[i]      = word_low_q[i*8 +: 8];
			name_tab[i + 8]  = word_mid_q[i*8 +: 8];
			name_tab[i + 16] = word_high_q[i*8 +: 8];
		end
	end

	assign eff_len = (name_len_q > NameLenW'(NAME_BYTES)) ? NameLenW'(NAME_BYTES) : name_len_q;

	// Parse state.
	phase_t              phase_q, phase_d;
	logic [NameLenW-1:0] pos_q, pos_d;
	logic                crp_q, crp_d;
	logic                after_q, after_d;
	logic [StatusW-1:0]  status_q, status_d;
	logic [LenW-1:0]     vlen_q, vlen_d;
	logic [LenW-1:0]     pend_q, pend_d;
	logic [AddrW-1:0]    idx_q;
	logic [ByteW-1:0]    held_q;

	logic             do_content, do_line_end, blank, name_hit, pos_lt, store;
	logic [ByteW-1:0] cbyte;
	logic             wr_en;
	logic [ByteW-1:0] rd_data;
	logic [AddrW-1:0] rd_addr;
	logic             present, idx_last;

	// A CR followed by a byte other than LF, CR or NUL yields two content bytes;
	// the second one is parsed from the hold register in the next cycle.
	assign sts.need_replay = (phase_q != PH_STOPPED) && crp_q && (in_byte != CH_NUL) &&
		(in_byte != CH_LF) && (in_byte != CH_CR);

	assign blank    = (cbyte == CH_SPACE) || (cbyte == CH_TAB);
	assign name_hit = fold_lower(cbyte) == fold_lower(name_tab[pos_q]);
	assign pos_lt   = pos_q < eff_len;

	always_comb begin
		phase_d     = phase_q;
		pos_d       = pos_q;
		crp_d       = crp_q;
		after_d     = after_q;
		status_d    = status_q;
		vlen_d      = vlen_q;
		pend_d      = pend_q;
		do_content  = 1'b0;
		do_line_end = 1'b0;
		cbyte       = held_q;
		store       = 1'b0;

		if (cmd.replay) begin
			do_content = 1'b1;
		end else if (cmd.take && phase_q != PH_STOPPED) begin
			if (in_byte == CH_NUL) begin
				phase_d = PH_STOPPED;
			end else if (crp_q) begin
				if (in_byte == CH_LF) begin
					crp_d       = 1'b0;
					do_line_end = 1'b1;
				end else begin
					do_content = 1'b1;
					cbyte      = CH_CR;
					if (in_byte != CH_CR) begin
						crp_d = 1'b0;
					end
				end
			end else if (in_byte == CH_CR) begin
				crp_d = 1'b1;
			end else begin
				do_content = 1'b1;
				cbyte      = in_byte;
			end
		end

		if (do_content) begin
			case (phase_q)
				PH_LINE_START, PH_NAME: begin
					if (phase_q == PH_LINE_START && after_q && blank) begin
						phase_d = PH_FOLDED;
					end else begin
						phase_d = PH_NAME;
						if (pos_lt) begin
							if (name_hit) begin
								pos_d = pos_q + NameLenW'(1);
							end else begin
								phase_d = PH_OTHER;
							end
						end else begin
							phase_d = (cbyte == CH_COLON) ? PH_BLANKS : PH_OTHER;
						end
					end
				end
				PH_BLANKS: begin
					if (!blank) begin
						store   = 1'b1;
						phase_d = PH_VALUE;
					end
				end
				PH_VALUE: begin
					store = 1'b1;
				end
				default: ;
			endcase
		end

		if (store && pend_q < LenW'(VALUE_MAX)) begin
			pend_d = pend_q + LenW'(1);
		end

		if (do_line_end) begin
			case (phase_q)
				PH_LINE_START: begin
					phase_d = PH_STOPPED;
				end
				PH_FOLDED: begin
					status_d = ST_INVALID;
					vlen_d   = '0;
					phase_d  = PH_STOPPED;
				end
				PH_BLANKS, PH_VALUE: begin
					if (status_q != ST_ABSENT || pend_q == '0 || pend_q >= LenW'(VALUE_MAX)) begin
						status_d = ST_INVALID;
						vlen_d   = '0;
						phase_d  = PH_STOPPED;
					end else begin
						status_d = ST_PRESENT;
						vlen_d   = pend_q;
						after_d  = 1'b1;
						phase_d  = PH_LINE_START;
						pos_d    = '0;
						pend_d   = '0;
					end
				end
				default: begin
					after_d = 1'b0;
					phase_d = PH_LINE_START;
					pos_d   = '0;
					pend_d  = '0;
				end
			endcase
		end

		if (cmd.clear) begin
			phase_d  = PH_LINE_START;
			pos_d    = '0;
			crp_d    = 1'b0;
			after_d  = 1'b0;
			status_d = ST_ABSENT;
			vlen_d   = '0;
			pend_d   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_LINE_START;
			pos_q    <= '0;
			crp_q    <= 1'b0;
			after_q  <= 1'b0;
			status_q <= ST_ABSENT;
			vlen_q   <= '0;
			pend_q   <= '0;
			idx_q    <= '0;
		end else begin
			phase_q  <= phase_d;
			pos_q    <= pos_d;
			crp_q    <= crp_d;
			after_q  <= after_d;
			status_q <= status_d;
			vlen_q   <= vlen_d;
			pend_q   <= pend_d;
			if (cmd.clear) begin
				idx_q <= '0;
			end else if (cmd.next_idx) begin
				idx_q <= idx_q + AddrW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			held_q <= in_byte;
		end
	end

	// Value store.
	assign wr_en   = store && (pend_q < LenW'(VALUE_MAX));
	assign rd_addr = cmd.rd_first ? idx_q : idx_q + AddrW'(1);

	hvc_ram #(
		.WIDTH(ByteW),
		.DEPTH(VALUE_MAX)
	) u_value_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(pend_q[AddrW-1:0]),
		.wr_data(cbyte),
		.rd_en  (cmd.rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// Output register.
	assign present  = (status_q == ST_PRESENT);
	assign idx_last = (LenW'(idx_q) + LenW'(1)) == vlen_q;

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_status <= status_q;
			out_byte   <= present ? rd_data : '0;
			out_last   <= !present || idx_last;
		end
	end

	assign sts.out_last = out_last;

endmodule

`default_nettype wire

FILE: sv/http_header_value_capture_top.sv
// HTTP header value capture, top level: stream channels and configuration port.
// Depends on hvc_pkg, hvc_ctrl, hvc_dp and hvc_ram.
//
// Usage: request bytes enter on the s_axis channel, one byte per transfer, with
// s_axis_tlast on the final byte of a request. Header lines end in CR LF; the
// line whose name equals the configured name (case-insensitive) followed by a
// colon supplies the value. The cfg channel writes the three name words and
// the name length by index; write it only while no request is in progress.
// Throughput: one request byte per cycle, except that after a CR followed by an
// ordinary byte the input stalls while the second content byte is replayed
// from a hold register into the single write port of the value store.
// After the last byte (and any replay step), the result run appears on m_axis:
// the value store is read in S_EMIT_RD and the output register loaded in
// S_EMIT_LD; while an item waits, the registered read of the value store
// prefetches the next entry. A found header gives one item per value
// byte with status present; otherwise a single item carries the status.
// No input is taken during the run; when the receiver stalls, the item holds
// on m_axis and the block waits. Reset clears the parse state and loads the
// default configuration (name length 22); the value store needs no clearing.
`timescale 1ns / 1ps
`default_nettype none

module http_header_value_capture_top
	import hvc_pkg::*;
#(
	parameter int VALUE_MAX  = VALUE_MAX_DEF,
	parameter int NAME_BYTES = NAME_BYTES_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// Configuration write channel.
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [CfgAddrW-1:0] cfg_addr,
	input  wire logic [CfgWordW-1:0] cfg_data,
	// Request bytes.
	input  wire logic                s_axis_tvalid,
	output logic                     s_axis_tready,
	input  wire logic [ByteW-1:0]    s_axis_tdata,  // [7:0] data_byte
	input  wire logic                s_axis_tlast,  // last_of_request
	// Result items.
	output logic                     m_axis_tvalid,
	input  wire logic                m_axis_tready,
	output logic      [OutDataW-1:0] m_axis_tdata,  // [1:0] status, [9:2] value_byte
	output logic                     m_axis_tlast   // last
);

	hvc_cmd_t           cmd;
	hvc_sts_t           sts;
	logic [StatusW-1:0] out_status;
	logic [ByteW-1:0]   out_byte;

	assign cfg_ready = 1'b1;

	hvc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_last  (s_axis_tlast),
		.in_ready (s_axis_tready),
		.out_ready(m_axis_tready),
		.out_valid(m_axis_tvalid),
		.sts      (sts),
		.cmd      (cmd)
	);

	hvc_dp #(
		.VALUE_MAX (VALUE_MAX),
		.NAME_BYTES(NAME_BYTES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data),
		.in_byte   (s_axis_tdata),
		.cmd       (cmd),
		.sts       (sts),
		.out_status(out_status),
		.out_byte  (out_byte),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = {(OutDataW - ByteW - StatusW)'(0), out_byte, out_status};

	// The input side stays closed while a result item is offered.
	a_no_input_during_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready)
		else $error("input ready while a result item is pending");

	// The final byte of a request closes the input side on the next cycle.
	a_closed_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
		else $error("input still ready after the last byte of a request");

	// A run without a value is a single item with a zero value byte.
	a_single_status_item: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[1:0] != ST_PRESENT) |->
		(m_axis_tlast && m_axis_tdata[9:2] == '0))
		else $error("status item without a value is malformed");

endmodule

`default_nettype wire
